[src/afc_pkg.sv]
// afc_pkg: shared constants, payload types and register codes for the box culling block
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps

package afc_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int PLANE_COUNT    = 6;
  localparam int NUM_PLANE_REGS = 6;
  localparam int TAG_W          = 16;
  localparam int NORM_W         = 16;
  localparam int FRAC_BITS      = 14;
  localparam int PROD_W         = COORD_WIDTH + NORM_W;
  localparam int D_TERM_W       = NORM_W + FRAC_BITS;
  // three products plus the shifted offset, exact
  localparam int SUM_W          = ((PROD_W + 2) > D_TERM_W ? (PROD_W + 2) : D_TERM_W) + 1;
  localparam int CFG_DATA_W     = 64;
  localparam int REG_IDX_W      = 3;
  localparam int CFG_ADDR_W     = REG_IDX_W + 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]      norm_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [TAG_W-1:0]              tag_t;
  typedef logic [PLANE_COUNT-1:0]        behind_vec_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    vec3_t lo;
    vec3_t hi;
  } box_t;

  // register layout: d in 63:48, nz 47:32, ny 31:16, nx 15:0
  typedef struct packed {
    norm_t d;
    norm_t nz;
    norm_t ny;
    norm_t nx;
  } plane_t;

  typedef struct packed {
    tag_t tag;
    logic visible;
  } result_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PLANE_FRONT  = 3'd0,
    REG_PLANE_BACK   = 3'd1,
    REG_PLANE_LEFT   = 3'd2,
    REG_PLANE_RIGHT  = 3'd3,
    REG_PLANE_TOP    = 3'd4,
    REG_PLANE_BOTTOM = 3'd5
  } reg_idx_t;

endpackage

[src/afc_if.sv]
// afc_if: valid/ready channel interfaces for boxes in and culling results out
// depends on afc_pkg for field widths
`timescale 1ns / 1ps

interface afc_box_if;
  logic                valid;
  logic                ready;
  afc_pkg::tag_t       element_id;
  afc_pkg::coord_t     box_min_x;
  afc_pkg::coord_t     box_min_y;
  afc_pkg::coord_t     box_min_z;
  afc_pkg::coord_t     box_max_x;
  afc_pkg::coord_t     box_max_y;
  afc_pkg::coord_t     box_max_z;

  modport source (
    output valid, element_id, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, element_id, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface afc_res_if;
  logic          valid;
  logic          ready;
  afc_pkg::tag_t element_tag;
  logic          visible;

  modport source (output valid, element_tag, visible, input ready);
  modport sink   (input valid, element_tag, visible, output ready);
endinterface

[src/aabb_frustum_cull.sv]
// path: each box passes the product, partial-sum and sign registers and then the output
// register, where its result is valid and is taken when not held; nothing is dropped
// throughput: one box per cycle while the skid is empty, set by the fully pipelined per-plane
// multiply and sum stages; stalls back up through a one-entry skid behind the output register
// reset: synchronous active-low rst_n clears all valid bits and sets every plane to zero,
// which makes every box visible until planes are written; no clearing pass
`timescale 1ns / 1ps

module aabb_frustum_cull (
  input  logic                           clk,
  input  logic                           rst_n,
  afc_box_if.sink                        in_box,
  afc_res_if.source                      out_res,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [afc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [afc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [afc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  afc_pkg::plane_t      planes [afc_pkg::NUM_PLANE_REGS];
  afc_pkg::box_t        box;
  afc_pkg::behind_vec_t behind;
  afc_pkg::tag_t        tag_r [3];
  logic [2:0]           v_r;
  logic                 adv;
  afc_pkg::result_t     push_data;
  afc_pkg::result_t     out_data;

  afc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .planes      (planes)
  );

  always_comb begin
    box.lo.x = in_box.box_min_x;
    box.lo.y = in_box.box_min_y;
    box.lo.z = in_box.box_min_z;
    box.hi.x = in_box.box_max_x;
    box.hi.y = in_box.box_max_y;
    box.hi.z = in_box.box_max_z;
  end

  // whole pipeline moves together while the skid has room
  assign in_box.ready = adv;

  for (genvar p = 0; p < afc_pkg::PLANE_COUNT; p++) begin : g_plane
    afc_plane u_plane (
      .clk    (clk),
      .adv    (adv),
      .box    (box),
      .plane  (planes[p]),
      .behind (behind[p])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], in_box.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= in_box.element_id;
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
    end
  end

  assign push_data.tag     = tag_r[2];
  assign push_data.visible = ~(|behind);

  afc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (v_r[2] & adv),
    .push_data (push_data),
    .room      (adv),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_data  (out_data)
  );

  assign out_res.element_tag = out_data.tag;
  assign out_res.visible     = out_data.visible;

endmodule

[src/afc_cfg.sv]
// afc_cfg: apb-style register file holding the six frustum planes
// depends on afc_pkg
`timescale 1ns / 1ps

module afc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [afc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [afc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [afc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output afc_pkg::plane_t                planes [afc_pkg::NUM_PLANE_REGS]
);

  afc_pkg::plane_t                plane_r [afc_pkg::NUM_PLANE_REGS];
  logic [afc_pkg::REG_IDX_W-1:0]  idx;
  logic                           idx_ok;
  logic                           wr_en;

  // registers sit on 8-byte boundaries
  assign idx    = cfg_paddr[afc_pkg::CFG_ADDR_W-1:3];
  assign idx_ok = (idx <= afc_pkg::REG_PLANE_BOTTOM);
  assign wr_en  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afc_pkg::NUM_PLANE_REGS; i++) begin
        plane_r[i] <= '0;
      end
    end else if (wr_en && idx_ok) begin
      plane_r[idx] <= afc_pkg::plane_t'(cfg_pwdata);
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (idx_ok) begin
      cfg_prdata = afc_pkg::CFG_DATA_W'(plane_r[idx]);
    end
  end

  assign planes = plane_r;

endmodule

[src/afc_plane.sv]
// afc_plane: three-stage test of one box against one plane
// products, then per-axis maximum and partial sum, then full sum and sign; uses afc_pkg
`timescale 1ns / 1ps

module afc_plane (
  input  logic            clk,
  input  logic            adv,
  input  afc_pkg::box_t   box,
  input  afc_pkg::plane_t plane,
  output logic            behind
);

  afc_pkg::norm_t  n      [3];
  afc_pkg::coord_t lo     [3];
  afc_pkg::coord_t hi     [3];
  afc_pkg::prod_t  lo_nxt [3];
  afc_pkg::prod_t  hi_nxt [3];
  afc_pkg::prod_t  lo_r   [3];
  afc_pkg::prod_t  hi_r   [3];
  afc_pkg::prod_t  top    [3];
  afc_pkg::sum_t   xy_nxt;
  afc_pkg::sum_t   xy_r;
  afc_pkg::prod_t  z_r;
  afc_pkg::sum_t   total;
  logic            behind_nxt;
  logic            behind_r;

  always_comb begin
    n[0]  = plane.nx;  n[1]  = plane.ny;  n[2]  = plane.nz;
    lo[0] = box.lo.x;  lo[1] = box.lo.y;  lo[2] = box.lo.z;
    hi[0] = box.hi.x;  hi[1] = box.hi.y;  hi[2] = box.hi.z;
    for (int a = 0; a < 3; a++) begin
      lo_nxt[a] = afc_pkg::prod_t'(n[a]) * afc_pkg::prod_t'(lo[a]);
      hi_nxt[a] = afc_pkg::prod_t'(n[a]) * afc_pkg::prod_t'(hi[a]);
    end
  end

  // the corner furthest in front takes the larger term on each axis,
  // so all eight corners are behind exactly when that one is
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      top[a] = (lo_r[a] > hi_r[a]) ? lo_r[a] : hi_r[a];
    end
    xy_nxt = afc_pkg::sum_t'(top[0]) + afc_pkg::sum_t'(top[1]);
  end

  always_comb begin
    total = xy_r + afc_pkg::sum_t'(z_r)
          + (afc_pkg::sum_t'(plane.d) <<< afc_pkg::FRAC_BITS);
    behind_nxt = total[afc_pkg::SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      xy_r     <= xy_nxt;
      z_r      <= top[2];
      behind_r <= behind_nxt;
    end
  end

  assign behind = behind_r;

endmodule

[src/afc_skid.sv]
// afc_skid: output register with one skid entry, so input ready never waits on output ready
// depends on afc_pkg for the result type
`timescale 1ns / 1ps

module afc_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  afc_pkg::result_t  push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output afc_pkg::result_t  out_data
);

  logic             main_v_r;
  logic             skid_v_r;
  afc_pkg::result_t main_r;
  afc_pkg::result_t skid_r;

  assign room      = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || out_ready) begin
        main_r   <= push_data;
        main_v_r <= 1'b1;
      end else begin
        skid_r   <= push_data;
        skid_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      main_v_r <= 1'b0;
    end
  end

endmodule

[src/afc_checker.sv]
// afc_checker: port-level assertions on the culling block, attached by bind
// depends on afc_pkg and the top level aabb_frustum_cull
`timescale 1ns / 1ps

module afc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input afc_pkg::tag_t out_tag,
  input logic          out_visible
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_visible))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // with nothing waiting at the output the skid is empty, so input is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // an accepted box reaches the output through the pipeline and output register if the sink keeps taking
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> ##1 out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_box.valid),
  .in_ready    (in_box.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_tag     (out_res.element_tag),
  .out_visible (out_res.visible)
);
